>>> hw/rtl/ccsc_pkg.sv
`timescale 1ns / 1ps

package ccsc_pkg;

    localparam int unsigned MAX_BITS  = 64;
    localparam int unsigned IDX_W     = $clog2(MAX_BITS);
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned APB_DW    = 64;

    // register indexes
    localparam logic [1:0] REG_DIVIDEND  = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_CODE_LEN  = 2'd2;
    localparam logic [1:0] REG_CHECK_ROW = 2'd3;

    localparam logic [MAX_BITS-1:0] DIVIDEND_RST  = MAX_BITS'(129);
    localparam logic [MAX_BITS-1:0] GENERATOR_RST = MAX_BITS'(11);
    localparam logic [LEN_W-1:0]    CODE_LEN_RST  = LEN_W'(7);
    localparam logic [LEN_W-1:0]    CHECK_ROW_RST = LEN_W'(3);

    typedef struct packed {
        logic [MAX_BITS-1:0] dividend_poly;
        logic [MAX_BITS-1:0] generator_poly;
        logic [LEN_W-1:0]    code_length;
        logic [LEN_W-1:0]    check_rows;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_JUDGE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_ROWS  = 5'b10000
    } state_t;

endpackage

>>> hw/rtl/ccsc_engine.sv
`timescale 1ns / 1ps

module ccsc_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ccsc_pkg::cfg_t                cfg,
    input  logic                          cfg_wr,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccsc_pkg::MAX_BITS-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ccsc_pkg::MAX_BITS-1:0] m_tdata,
    output logic                          m_tuser
);

    localparam int unsigned W  = ccsc_pkg::MAX_BITS;
    localparam int unsigned IW = ccsc_pkg::IDX_W;
    localparam int unsigned LW = ccsc_pkg::LEN_W;

    ccsc_pkg::state_t state_reg, state_next;

    logic [IW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  den_sh_reg, den_sh_next;
    logic [W-1:0]  num_sh_reg, num_sh_next;
    logic [IW-1:0] dg_reg, dg_next;
    logic [IW-1:0] dn_reg, dn_next;
    logic          dg_found_reg, dg_found_next;
    logic          dn_found_reg, dn_found_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic          ready_reg, ready_next;
    logic          fault_reg, fault_next;
    logic [W-1:0]  cw_sh_reg, cw_sh_next;
    logic [W-1:0]  syn_reg, syn_next;
    logic [IW-1:0] row_reg, row_next;
    logic          emit_reg, emit_next;
    logic          m_valid_reg, m_valid_next;
    logic [W-1:0]  m_data_reg, m_data_next;
    logic          m_err_reg, m_err_next;

    logic [LW-1:0] n_eff, r_eff;
    logic [W-1:0]  cw_mask, cw_rev;
    logic [LW-1:0] load_shift;
    logic [W-1:0]  rem_sh;
    logic          q_bit;
    logic          accept, slot_free, last_row;

    always_comb begin
        n_eff = (cfg.code_length > LW'(W)) ? LW'(W) : cfg.code_length;
        r_eff = (cfg.check_rows  > LW'(W)) ? LW'(W) : cfg.check_rows;
        // column j of row 0 lines up with bit n-1-j of the reversed word after the load shift
        cw_mask = s_tdata & ~({W{1'b1}} << n_eff);
        for (int k = 0; k < W; k++) begin
            cw_rev[k] = cw_mask[W-1-k];
        end
        load_shift = LW'(W) - n_eff;
        rem_sh     = {rem_reg[W-2:0], cfg.dividend_poly[cnt_reg]};
        q_bit      = rem_sh[dg_reg];
        last_row   = ({1'b0, row_reg} == (r_eff - LW'(1)));
    end

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ccsc_pkg::ST_IDLE) && !emit_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        den_sh_next   = den_sh_reg;
        num_sh_next   = num_sh_reg;
        dg_next       = dg_reg;
        dn_next       = dn_reg;
        dg_found_next = dg_found_reg;
        dn_found_next = dn_found_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        ready_next    = ready_reg;
        fault_next    = fault_reg;
        cw_sh_next    = cw_sh_reg;
        syn_next      = syn_reg;
        row_next      = row_reg;
        emit_next     = emit_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_err_next    = m_err_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ccsc_pkg::ST_IDLE: begin
                if (emit_reg && slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = syn_reg;
                    m_err_next   = fault_reg;
                    emit_next    = 1'b0;
                end else if (accept) begin
                    cw_sh_next = cw_rev >> load_shift;
                    syn_next   = '0;
                    row_next   = '0;
                    if (!ready_reg) begin
                        state_next    = ccsc_pkg::ST_SCAN;
                        cnt_next      = IW'(W - 1);
                        den_sh_next   = cfg.generator_poly;
                        num_sh_next   = cfg.dividend_poly;
                        dg_found_next = 1'b0;
                        dn_found_next = 1'b0;
                        dg_next       = '0;
                        dn_next       = '0;
                    end else if (fault_reg || r_eff == '0) begin
                        emit_next = 1'b1;
                    end else begin
                        state_next = ccsc_pkg::ST_ROWS;
                    end
                end
            end
            ccsc_pkg::ST_SCAN: begin
                // degree search, top bit first
                if (den_sh_reg[W-1] && !dg_found_reg) begin
                    dg_found_next = 1'b1;
                    dg_next       = cnt_reg;
                end
                if (num_sh_reg[W-1] && !dn_found_reg) begin
                    dn_found_next = 1'b1;
                    dn_next       = cnt_reg;
                end
                den_sh_next = den_sh_reg << 1;
                num_sh_next = num_sh_reg << 1;
                cnt_next    = cnt_reg - IW'(1);
                if (cnt_reg == '0) begin
                    state_next = ccsc_pkg::ST_JUDGE;
                end
            end
            ccsc_pkg::ST_JUDGE: begin
                rem_next = '0;
                q_next   = '0;
                cnt_next = IW'(W - 1);
                if (!dg_found_reg || !dn_found_reg || dg_reg > dn_reg) begin
                    fault_next = 1'b1;
                    ready_next = 1'b1;
                    emit_next  = 1'b1;
                    state_next = ccsc_pkg::ST_IDLE;
                end else begin
                    state_next = ccsc_pkg::ST_DIV;
                end
            end
            ccsc_pkg::ST_DIV: begin
                // long division, one dividend bit per cycle
                rem_next = q_bit ? (rem_sh ^ cfg.generator_poly) : rem_sh;
                q_next   = {q_reg[W-2:0], q_bit};
                cnt_next = cnt_reg - IW'(1);
                if (cnt_reg == '0) begin
                    ready_next = 1'b1;
                    fault_next = 1'b0;
                    if (r_eff == '0) begin
                        emit_next  = 1'b1;
                        state_next = ccsc_pkg::ST_IDLE;
                    end else begin
                        state_next = ccsc_pkg::ST_ROWS;
                    end
                end
            end
            ccsc_pkg::ST_ROWS: begin
                syn_next[row_reg] = ^(q_reg & cw_sh_reg);
                cw_sh_next        = cw_sh_reg >> 1;
                row_next          = row_reg + IW'(1);
                if (last_row) begin
                    emit_next  = 1'b1;
                    state_next = ccsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ccsc_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ccsc_pkg::ST_IDLE;
            ready_reg    <= 1'b0;
            fault_reg    <= 1'b0;
            emit_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            q_reg        <= '0;
            rem_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            fault_reg    <= fault_next;
            emit_reg     <= emit_next;
            m_valid_reg  <= m_valid_next;
            q_reg        <= q_next;
            rem_reg      <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        den_sh_reg   <= den_sh_next;
        num_sh_reg   <= num_sh_next;
        dg_reg       <= dg_next;
        dn_reg       <= dn_next;
        dg_found_reg <= dg_found_next;
        dn_found_reg <= dn_found_next;
        cw_sh_reg    <= cw_sh_next;
        syn_reg      <= syn_next;
        row_reg      <= row_next;
        m_data_reg   <= m_data_next;
        m_err_reg    <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

endmodule

>>> hw/rtl/cyclic_code_syndrome_checker_core.sv
`timescale 1ns / 1ps
// with the check polynomial in place a request steps through ST_ROWS, one row per
// cycle (r = rows, capped at 64), and the syndrome then goes to the output register
// once it is free; with no rows or a config error ST_ROWS is skipped
// one codeword in flight at a time; after any register write the next codeword also
// runs the degree search and, unless refused, the bit-serial long division
// aresetn is synchronous, active low; registers return to x^7+1, x^3+x+1, n=7, r=3

module cyclic_code_syndrome_checker_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccsc_pkg::APB_DW-1:0]   pwdata,
    output logic [ccsc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // codeword requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccsc_pkg::MAX_BITS-1:0] s_tdata,  // [63:0] codeword
    // syndrome results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ccsc_pkg::MAX_BITS-1:0] m_tdata,  // [63:0] syndrome
    output logic                          m_tuser   // [0] config_error
);

    ccsc_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    // registers sit on 8-byte boundaries
    assign reg_idx = paddr[ccsc_pkg::ADDR_W-1:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                ccsc_pkg::REG_DIVIDEND:  cfg_next.dividend_poly  = pwdata;
                ccsc_pkg::REG_GENERATOR: cfg_next.generator_poly = pwdata;
                ccsc_pkg::REG_CODE_LEN:  cfg_next.code_length = pwdata[ccsc_pkg::LEN_W-1:0];
                ccsc_pkg::REG_CHECK_ROW: cfg_next.check_rows  = pwdata[ccsc_pkg::LEN_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dividend_poly  <= ccsc_pkg::DIVIDEND_RST;
            cfg_reg.generator_poly <= ccsc_pkg::GENERATOR_RST;
            cfg_reg.code_length    <= ccsc_pkg::CODE_LEN_RST;
            cfg_reg.check_rows     <= ccsc_pkg::CHECK_ROW_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register readback, narrow fields zero extended
    always_comb begin
        unique case (reg_idx)
            ccsc_pkg::REG_DIVIDEND:  prdata = cfg_reg.dividend_poly;
            ccsc_pkg::REG_GENERATOR: prdata = cfg_reg.generator_poly;
            ccsc_pkg::REG_CODE_LEN:  prdata = ccsc_pkg::APB_DW'(cfg_reg.code_length);
            ccsc_pkg::REG_CHECK_ROW: prdata = ccsc_pkg::APB_DW'(cfg_reg.check_rows);
            default:                 prdata = '0;
        endcase
    end

    // division, syndrome sequencer and output register
    ccsc_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cfg_wr   (wr_en),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/sv/tb_cyclic_code_syndrome_checker_core.sv
`timescale 1ns / 1ps

module tb_cyclic_code_syndrome_checker_core;

    // one directed probe: configuration, codeword and, where obvious, the syndrome
    typedef struct {
        logic [63:0] dividend;
        logic [63:0] generator;
        logic [6:0]  length;
        logic [6:0]  rows;
        logic [63:0] codeword;
        bit          known;
        logic [63:0] syndrome;
        bit          cfg_err;
    } probe_t;

    typedef struct {
        logic [63:0] syndrome;
        bit          cfg_err;
    } syndrome_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ccsc_pkg::ADDR_W-1:0]   paddr;
    logic [ccsc_pkg::APB_DW-1:0]   pwdata;
    logic [ccsc_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ccsc_pkg::MAX_BITS-1:0] s_tdata;   // [63:0] codeword
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ccsc_pkg::MAX_BITS-1:0] m_tdata;   // [63:0] syndrome
    logic                          m_tuser;   // [0] config_error

    // mirror of the configuration and the check polynomial derived from it
    logic [63:0] cur_dividend;
    logic [63:0] cur_generator;
    logic [6:0]  cur_length;
    logic [6:0]  cur_rows;
    logic [63:0] check_poly;
    bit          div_fault;

    probe_t      probes[$];
    syndrome_t   pending_syndromes[$];
    int          mismatch_count;
    int          burst_left;
    bit          send_gappy;
    int          recv_mode;
    int          hold_off_cycles;

    cyclic_code_syndrome_checker_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("cyclic_code_syndrome_checker_core regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic int poly_degree(logic [63:0] v);
        int d;
        d = -1;
        for (int k = 0; k < 64; k++) begin
            if (v[k]) d = k;
        end
        return d;
    endfunction

    // gf(2) long division of the dividend by the generator, quotient kept as h
    function automatic void derive_check_poly();
        logic [63:0] rem;
        logic [63:0] quo;
        int          gdeg;
        int          s;
        rem  = cur_dividend;
        quo  = '0;
        gdeg = poly_degree(cur_generator);
        div_fault = (gdeg < 0) || (gdeg > poly_degree(cur_dividend));
        if (!div_fault) begin
            while (rem != 0 && poly_degree(rem) >= gdeg) begin
                s = poly_degree(rem) - gdeg;
                quo[s] = 1'b1;
                rem ^= cur_generator << s;
            end
        end
        check_poly = div_fault ? '0 : quo;
    endfunction

    // row i, column j of the check matrix is h[n-1-i-j]
    function automatic syndrome_t predict_syndrome(logic [63:0] cw);
        syndrome_t res;
        int        n;
        int        r;
        int        t;
        bit        par;
        n = (cur_length > 64) ? 64 : int'(cur_length);
        r = (cur_rows > 64) ? 64 : int'(cur_rows);
        res.syndrome = '0;
        res.cfg_err  = div_fault;
        if (!div_fault) begin
            for (int i = 0; i < r; i++) begin
                par = 1'b0;
                for (int j = 0; j < n; j++) begin
                    t = n - 1 - i - j;
                    if (t >= 0) par ^= check_poly[t] & cw[j];
                end
                res.syndrome[i] = par;
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] low_mask(int bits);
        return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic logic [63:0] gf2_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] prod;
        prod = '0;
        for (int k = 0; k < 64; k++) begin
            if (b[k]) prod ^= a << k;
        end
        return prod;
    endfunction

    // mostly code words (message times generator), some with a flipped bit,
    // some with junk above the code length; the rest plain noise
    function automatic logic [63:0] pick_codeword();
        logic [63:0] cw;
        int          n;
        int          gdeg;
        n    = (cur_length > 64) ? 64 : int'(cur_length);
        gdeg = poly_degree(cur_generator);
        if ($urandom_range(0, 99) < 70 && !div_fault && n > gdeg) begin
            cw = gf2_mul(rand64() & low_mask(n - gdeg), cur_generator) & low_mask(n);
            if ($urandom_range(0, 4) == 0) cw[$urandom_range(0, n - 1)] ^= 1'b1;
            if ($urandom_range(0, 2) == 0) cw |= rand64() & ~low_mask(n);
        end else begin
            cw = rand64();
        end
        return cw;
    endfunction

    function automatic void add_probe(logic [63:0] dvd, logic [63:0] gen, logic [6:0] len,
                                      logic [6:0] rows, logic [63:0] cw, bit known,
                                      logic [63:0] syn, bit err);
        probe_t pr;
        pr.dividend  = dvd;
        pr.generator = gen;
        pr.length    = len;
        pr.rows      = rows;
        pr.codeword  = cw;
        pr.known     = known;
        pr.syndrome  = syn;
        pr.cfg_err   = err;
        probes.push_back(pr);
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read one register back and compare
    task automatic apb_read(logic [1:0] idx, logic [63:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("register %0d readback at %0t: expected %h, got %h",
                         idx, $realtime, want, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drop valid at the next falling edge so no stale request gets taken
    task automatic quiet_sender();
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        burst_left = 0;
    endtask

    // registers only change with nothing in flight
    task automatic apply_config(logic [63:0] dvd, logic [63:0] gen, logic [6:0] len,
                                logic [6:0] rows);
        quiet_sender();
        while (pending_syndromes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        // spare bits above the length fields carry junk, the block keeps 7 bits
        apb_write(ccsc_pkg::REG_DIVIDEND, dvd);
        apb_write(ccsc_pkg::REG_GENERATOR, gen);
        apb_write(ccsc_pkg::REG_CODE_LEN, {57'(rand64() >> 7), len});
        apb_write(ccsc_pkg::REG_CHECK_ROW, {57'(rand64() >> 7), rows});
        apb_read(ccsc_pkg::REG_DIVIDEND, dvd);
        apb_read(ccsc_pkg::REG_GENERATOR, gen);
        apb_read(ccsc_pkg::REG_CODE_LEN, 64'(len));
        apb_read(ccsc_pkg::REG_CHECK_ROW, 64'(rows));
        cur_dividend  = dvd;
        cur_generator = gen;
        cur_length    = len;
        cur_rows      = rows;
        derive_check_poly();
    endtask

    // offer one codeword, bursts and gaps at random; returns at the accepting edge
    task automatic send_codeword(logic [63:0] cw, bit known, logic [63:0] syn, bit err);
        syndrome_t exp;
        int        gap;
        @(negedge aclk);
        if (send_gappy && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= cw;
        do @(posedge aclk); while (!s_tready);
        if (known) begin
            exp.syndrome = syn;
            exp.cfg_err  = err;
        end else begin
            exp = predict_syndrome(cw);
        end
        pending_syndromes.push_back(exp);
    endtask

    // ---------------------------------------------------------------
    // receiver: own stall pattern plus one long hold-off on request
    // ---------------------------------------------------------------

    initial begin
        int tick;
        m_tready = 1'b0;
        tick     = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_off_cycles > 0) begin
                // long stall so the block backs up and drops s_tready
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(negedge aclk);
                hold_off_cycles = 0;
            end else begin
                case (recv_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 99) >= 35);
                    2: m_tready <= ((tick % 7) < 4);
                    default: m_tready <= ((tick % 40) >= 12);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        syndrome_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_syndromes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected syndrome %h err %b at %0t", m_tdata, m_tuser,
                             $realtime);
            end else begin
                exp = pending_syndromes.pop_front();
                if (m_tdata !== exp.syndrome || m_tuser !== exp.cfg_err) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("syndrome mismatch at %0t: expected %h err %b, got %h err %b",
                                 $realtime, exp.syndrome, exp.cfg_err, m_tdata, m_tuser);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        probe_t      pr;
        logic [63:0] dvd;
        logic [63:0] gen;
        logic [6:0]  len;
        logic [6:0]  rows;

        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        mismatch_count  = 0;
        burst_left      = 0;
        send_gappy      = 1'b1;
        recv_mode       = 1;
        hold_off_cycles = 0;

        // state after reset: x^7+1 over x^3+x+1, n=7, r=3
        cur_dividend  = ccsc_pkg::DIVIDEND_RST;
        cur_generator = ccsc_pkg::GENERATOR_RST;
        cur_length    = ccsc_pkg::CODE_LEN_RST;
        cur_rows      = ccsc_pkg::CHECK_ROW_RST;
        derive_check_poly();

        // directed probes: reset setting, error cases, degenerate sizes, extremes
        add_probe(129, 11, 7, 3, 64'h0, 1, 64'h0, 0);
        add_probe(129, 11, 7, 3, '1, 0, 0, 0);
        add_probe(129, 11, 7, 3, 64'h5A, 0, 0, 0);
        add_probe(129, 11, 7, 3, 64'h0B, 0, 0, 0);
        // zero generator
        add_probe(129, 0, 7, 3, '1, 1, 64'h0, 1);
        // generator of higher degree than dividend
        add_probe(64'h9, 64'h13, 7, 3, '1, 1, 64'h0, 1);
        // zero dividend sits below every generator
        add_probe(64'h0, 64'h1, 7, 3, '1, 1, 64'h0, 1);
        // equal degrees give quotient 1
        add_probe(64'h81, 64'h83, 7, 3, '1, 0, 0, 0);
        add_probe(64'h81, 64'h83, 7, 3, 64'h40, 0, 0, 0);
        // no columns, then no rows
        add_probe(129, 11, 0, 3, '1, 1, 64'h0, 0);
        add_probe(129, 11, 7, 0, '1, 1, 64'h0, 0);
        // more rows than columns
        add_probe(64'h11, 64'h3, 4, 10, 64'hF, 0, 0, 0);
        add_probe(64'h11, 64'h3, 4, 10, 64'hFFFF_FFFF_FFFF_FFF5, 0, 0, 0);
        // full width, and lengths past the width
        add_probe('1, 64'h1, 64, 64, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0);
        add_probe('1, 64'h1, 64, 64, 64'h5555_5555_5555_5555, 0, 0, 0);
        add_probe(64'h8000_0000_0000_0001, 64'h3, 127, 127, '1, 0, 0, 0);
        add_probe(64'h8000_0000_0000_0001, 64'h3, 65, 65, 64'h8000_0000_0000_0000, 0, 0, 0);
        // top bits on both, equal degree
        add_probe('1, 64'h8000_0000_0000_0000, 64, 64, '1, 0, 0, 0);
        // smallest code
        add_probe(64'h1, 64'h1, 1, 1, 64'h1, 0, 0, 0);
        add_probe(64'h1, 64'h1, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (probes[k]) begin
            pr = probes[k];
            if (pr.dividend !== cur_dividend || pr.generator !== cur_generator ||
                pr.length !== cur_length || pr.rows !== cur_rows)
                apply_config(pr.dividend, pr.generator, pr.length, pr.rows);
            send_codeword(pr.codeword, pr.known, pr.syndrome, pr.cfg_err);
        end

        // random part: a dozen settings, eight fixed and mostly real cyclic codes, four random
        for (int p = 0; p < 12; p++) begin
            case (p)
                0: begin dvd = 129; gen = 11; len = 7; rows = 3; end
                1: begin dvd = 64'h8001; gen = 64'h13; len = 15; rows = 4; end
                2: begin dvd = 64'h80_0001; gen = 64'hC75; len = 23; rows = 11; end
                3: begin dvd = 64'h8000_0000_0000_0001; gen = 64'h43; len = 63; rows = 6; end
                4: begin dvd = '1; gen = '1; len = 127; rows = 127; end
                5: begin dvd = 64'h8000_0000_0000_0001; gen = 64'h3; len = 64; rows = 64; end
                6: begin dvd = 64'h3; gen = 64'h1; len = 1; rows = 1; end
                7: begin dvd = 64'h8000_0001; gen = 64'h25; len = 31; rows = 5; end
                default: begin
                    // anything goes, now and then a zero or oversized generator
                    dvd  = rand64() >> $urandom_range(0, 63);
                    gen  = ($urandom_range(0, 7) == 0) ? 64'h0
                                                      : rand64() >> $urandom_range(0, 63);
                    len  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                      : 7'($urandom_range(1, 64));
                    rows = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                      : 7'($urandom_range(1, 64));
                end
            endcase
            apply_config(dvd, gen, len, rows);
            send_gappy = (p % 3 != 1);
            recv_mode  = p % 4;
            // one long receiver stall while requests keep coming
            if (p == 2) hold_off_cycles = 400;
            for (int i = 0; i < 84; i++)
                send_codeword(pick_codeword(), 0, 0, 0);
        end

        quiet_sender();
        while (pending_syndromes.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("cyclic_code_syndrome_checker_core regression: pass");
        end else begin
            $display("cyclic_code_syndrome_checker_core regression: fail");
        end
        $finish;
    end

endmodule

>>> cyclic_code_syndrome_checker_core.f
hw/rtl/ccsc_pkg.sv
hw/rtl/ccsc_engine.sv
hw/rtl/cyclic_code_syndrome_checker_core.sv
tb/sv/tb_cyclic_code_syndrome_checker_core.sv
